// ----- sv/scaled_matrix_multiply_assert.svh -----
// Assertion macros for the scaled matrix multiply checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SCALED_MATRIX_MULTIPLY_ASSERT_SVH
`define SCALED_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- sv/smm_pkg.sv -----
// Shared constants, types and helper functions of the scaled matrix multiply.
// Used by the controller, the datapath, the top level and the checker.
package smm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 16;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam int FIELD_IDX_W = 3;
  localparam int VALUE_IN_W  = 16;
  localparam int OPCODE_W    = 2;
  localparam int DIM_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int ACC_W       = 35;
  localparam int VAL_W       = 36;
  localparam int SUM_W       = 64;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  localparam logic [OPCODE_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } smm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   wr_a;
    logic                   wr_b;
    logic                   issue;
    logic [FIELD_IDX_W-1:0] rd_i;
    logic [FIELD_IDX_W-1:0] rd_k;
    logic [FIELD_IDX_W-1:0] rd_j;
    logic                   acc_clr;
    logic                   out_load;
    logic                   out_last;
  } smm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } smm_sts_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    res = (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [FIELD_IDX_W-1:0] row,
                                                input logic [FIELD_IDX_W-1:0] col);
    logic [31:0] lin;
    lin = 32'(row) * MAX_DIM + 32'(col);
    return lin[ADDR_W-1:0];
  endfunction

  function automatic logic in_range(input logic [FIELD_IDX_W-1:0] row,
                                    input logic [FIELD_IDX_W-1:0] col);
    logic ok;
    ok = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    return ok;
  endfunction

  // The loaded Q8.8 value is sign-extended and then cut to the store width.
  function automatic logic [ELEM_WIDTH-1:0] elem_of(input logic signed [VALUE_IN_W-1:0] v);
    logic signed [SUM_W-1:0] w;
    w = SUM_W'(v);
    return w[ELEM_WIDTH-1:0];
  endfunction

endpackage

// ----- sv/smm_ctrl.sv -----
// Controller of the scaled matrix multiply: configuration registers, input
// handshake and the row/column/inner sequencer. Depends on smm_pkg.
module smm_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smm_pkg::OPCODE_W-1:0]    in_tuser,
  input  logic                            cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smm_pkg::DIM_W-1:0]       cfg_data,
  input  smm_pkg::smm_sts_t               sts,
  output smm_pkg::smm_cmd_t               cmd
);

  smm_pkg::smm_state_t state_r, state_nxt;

  logic [smm_pkg::DIM_W-1:0] rows_a_r, inner_size_r, cols_b_r;
  logic [smm_pkg::IDX_W-1:0] i_r, j_r, k_r;
  logic [smm_pkg::IDX_W-1:0] i_nxt, j_nxt, k_nxt;

  logic [smm_pkg::DIM_W-1:0] dim_m, dim_k, dim_n;
  logic accept, start, k_last, i_last, j_last;

  assign dim_m = smm_pkg::clamp_dim(rows_a_r);
  assign dim_k = smm_pkg::clamp_dim(inner_size_r);
  assign dim_n = smm_pkg::clamp_dim(cols_b_r);

  assign in_tready = (state_r == smm_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // A compute item with no rows or no columns leaves the block idle.
  assign start     = accept && (in_tuser == smm_pkg::OP_COMPUTE) &&
                     (dim_m != '0) && (dim_n != '0);

  assign k_last = (smm_pkg::DIM_W'(k_r) + smm_pkg::DIM_W'(1)) == dim_k;
  assign i_last = (smm_pkg::DIM_W'(i_r) + smm_pkg::DIM_W'(1)) == dim_m;
  assign j_last = (smm_pkg::DIM_W'(j_r) + smm_pkg::DIM_W'(1)) == dim_n;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (dim_k != '0) ? smm_pkg::ST_ISSUE : smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_ISSUE: begin
        if (k_last) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = smm_pkg::ST_EMIT;
        end
      end
      smm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (i_last && j_last) begin
            state_nxt = smm_pkg::ST_IDLE;
          end else if (dim_k != '0) begin
            state_nxt = smm_pkg::ST_ISSUE;
          end else begin
            state_nxt = smm_pkg::ST_DRAIN;
          end
        end
      end
      default: state_nxt = smm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_a     = accept && (in_tuser == smm_pkg::OP_LOAD_A);
    cmd.wr_b     = accept && (in_tuser == smm_pkg::OP_LOAD_B);
    cmd.rd_i     = smm_pkg::FIELD_IDX_W'(i_r);
    cmd.rd_k     = smm_pkg::FIELD_IDX_W'(k_r);
    cmd.rd_j     = smm_pkg::FIELD_IDX_W'(j_r);
    cmd.out_last = i_last && j_last;
    unique case (state_r)
      smm_pkg::ST_IDLE:  cmd.acc_clr = 1'b1;
      smm_pkg::ST_ISSUE: cmd.issue = 1'b1;
      smm_pkg::ST_DRAIN: cmd.issue = 1'b0;
      smm_pkg::ST_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.acc_clr  = sts.out_free;
      end
      default: cmd.issue = 1'b0;
    endcase
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    unique case (state_r)
      smm_pkg::ST_IDLE: begin
        if (start) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      smm_pkg::ST_ISSUE: begin
        k_nxt = k_last ? '0 : k_r + smm_pkg::IDX_W'(1);
      end
      smm_pkg::ST_DRAIN: k_nxt = '0;
      smm_pkg::ST_EMIT: begin
        if (sts.out_free && !(i_last && j_last)) begin
          if (j_last) begin
            j_nxt = '0;
            i_nxt = i_r + smm_pkg::IDX_W'(1);
          end else begin
            j_nxt = j_r + smm_pkg::IDX_W'(1);
          end
        end
      end
      default: k_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= smm_pkg::DIM_RESET;
      inner_size_r <= smm_pkg::DIM_RESET;
      cols_b_r     <= smm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smm_pkg::CFG_ROWS_A:     rows_a_r     <= cfg_data;
        smm_pkg::CFG_INNER_SIZE: inner_size_r <= cfg_data;
        smm_pkg::CFG_COLS_B:     cols_b_r     <= cfg_data;
        default:                 rows_a_r     <= rows_a_r;
      endcase
    end
  end

endmodule

// ----- sv/smm_datapath.sv -----
// Datapath of the scaled matrix multiply: the two element stores, the
// multiply-accumulate pipeline and the output register. Depends on smm_pkg.
module smm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smm_pkg::smm_cmd_t                   cmd,
  output smm_pkg::smm_sts_t                   sts,
  input  logic [smm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [smm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  logic [smm_pkg::ELEM_WIDTH-1:0] mem_a [smm_pkg::DEPTH];
  logic [smm_pkg::ELEM_WIDTH-1:0] mem_b [smm_pkg::DEPTH];

  logic [smm_pkg::FIELD_IDX_W-1:0]       in_row, in_col;
  logic signed [smm_pkg::VALUE_IN_W-1:0] in_val;
  logic [smm_pkg::ADDR_W-1:0]            wr_addr, rd_addr_a, rd_addr_b;
  logic                                  wr_ok;

  logic signed [smm_pkg::ELEM_WIDTH-1:0]   rd_a_r, rd_b_r;
  logic signed [2*smm_pkg::ELEM_WIDTH-1:0] prod_full;
  logic signed [smm_pkg::SUM_W-1:0]        prod_ext;
  logic [smm_pkg::ACC_W-1:0]               prod_r, prod_nxt, acc_r, acc_nxt;
  logic                                    v1_r, v2_r;

  logic                             out_valid_r, out_valid_nxt, out_last_r;
  logic [smm_pkg::FIELD_IDX_W-1:0]  out_row_r, out_col_r;
  logic [smm_pkg::VAL_W-1:0]        out_val_r, out_val_nxt;

  assign in_row = in_tdata[smm_pkg::FIELD_IDX_W-1:0];
  assign in_col = in_tdata[2*smm_pkg::FIELD_IDX_W-1:smm_pkg::FIELD_IDX_W];
  assign in_val = in_tdata[2*smm_pkg::FIELD_IDX_W +: smm_pkg::VALUE_IN_W];

  assign wr_addr   = smm_pkg::addr_of(in_row, in_col);
  assign wr_ok     = smm_pkg::in_range(in_row, in_col);
  assign rd_addr_a = smm_pkg::addr_of(cmd.rd_i, cmd.rd_k);
  assign rd_addr_b = smm_pkg::addr_of(cmd.rd_k, cmd.rd_j);

  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_ok) begin
      mem_a[wr_addr] <= smm_pkg::elem_of(in_val);
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b && wr_ok) begin
      mem_b[wr_addr] <= smm_pkg::elem_of(in_val);
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  // Only the low bits of the sum matter, as the result is taken modulo its width.
  assign prod_full = rd_a_r * rd_b_r;
  assign prod_ext  = smm_pkg::SUM_W'(prod_full);
  assign prod_nxt  = prod_ext[smm_pkg::ACC_W-1:0];

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  assign out_val_nxt = smm_pkg::VAL_W'(0) - {acc_r, 1'b0};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.out_load) begin
      out_row_r  <= cmd.rd_i;
      out_col_r  <= cmd.rd_j;
      out_val_r  <= out_val_nxt;
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(smm_pkg::OUT_TDATA_W - 2*smm_pkg::FIELD_IDX_W - smm_pkg::VAL_W){1'b0}},
                       out_val_r, out_col_r, out_row_r};

endmodule

// ----- sv/scaled_matrix_multiply.sv -----
// Scaled matrix multiply, C = -2 * A * B, signed Q8.8 in and Q20.16 out.
// Top level joining the controller and the datapath. Depends on smm_pkg.
//
// Usage:
//   The input channel carries an opcode in in_tuser: load an element of A,
//   load an element of B, or compute. Loads take one transfer per cycle while the
//   block is idle and write the element store at row*MAX_DIM+col; a load outside
//   the matrix range or an unused opcode is dropped. A compute transfer walks the
//   stores and sends every element of C in row-major order on the output
//   channel, with out_tlast on the final element.
//   Each result element is built by store reads for each inner index through
//   the single read port of each store, then the read, multiply and accumulate
//   pipeline drains and the element is loaded into the output register. With an
//   inner size of zero no store reads are issued.
//   in_tready is low while a compute runs. If the receiver stalls, the
//   finished element waits in the output register and the walk pauses.
//   Reset restores every dimension register to 8 and empties the pipeline
//   and output register; the stores keep no reset and must be loaded first.
//   Dimension registers are written on the cfg port; the user must do so only
//   while the block is idle, as the block itself does not enforce it.
module scaled_matrix_multiply (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, lowest bit up: row_index[2:0], col_index[5:3], element_value[21:6], zero
  input  logic [smm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [smm_pkg::OPCODE_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, lowest bit up: out_row[2:0], out_col[5:3], product_value[41:6], zero
  output logic [smm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smm_pkg::DIM_W-1:0]         cfg_data
);

  smm_pkg::smm_cmd_t cmd;
  smm_pkg::smm_sts_t sts;

  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  smm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sv/smm_checker.sv -----
// Port-level checker for the scaled matrix multiply, bound to the top level.
// Depends on smm_pkg and the assertion macros header.
`include "scaled_matrix_multiply_assert.svh"

module smm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [smm_pkg::OPCODE_W-1:0]      in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [smm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_we,
  input logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [smm_pkg::DIM_W-1:0]         cfg_data
);

  // Shadow copies of the row and column counts, taken from the cfg port.
  logic [smm_pkg::DIM_W-1:0] rows_r, cols_r;
  logic                      compute_go;
  logic                      out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= smm_pkg::DIM_RESET;
      cols_r <= smm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == smm_pkg::CFG_ROWS_A) begin
        rows_r <= cfg_data;
      end
      if (cfg_index == smm_pkg::CFG_COLS_B) begin
        cols_r <= cfg_data;
      end
    end
  end

  assign compute_go = in_tvalid && in_tready && (in_tuser == smm_pkg::OP_COMPUTE) &&
                      (rows_r != '0) && (cols_r != '0);
  assign out_stall  = out_tvalid && !out_tready;

  // A stalled result must stay put until the receiver takes it.
  `SMM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // While a non-final element is pending the walk is still running.
  `SMM_ASSERT_SAME(a_busy_mid_matrix, out_tvalid && !out_tlast, !in_tready)

  // A compute transfer that yields results closes the input channel next cycle.
  `SMM_ASSERT_NEXT(a_compute_blocks, compute_go, !in_tready)

endmodule

bind scaled_matrix_multiply smm_checker u_smm_checker (.*);
